/* design/hyperspherical_cholesky_factor_defines.svh */
// Assertion macros used by the hyperspherical Cholesky factor checker.
`ifndef HYPERSPHERICAL_CHOLESKY_FACTOR_DEFINES_SVH
`define HYPERSPHERICAL_CHOLESKY_FACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCF_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define HCF_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

/* design/hcf_pkg.sv */
// Shared constants, state encoding and control/status types of the Cholesky factor block.
package hcf_pkg;

	localparam int MAX_DIM = 16;
	localparam int MIN_DIM = 2;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = $clog2(MAX_DIM + 1);

	localparam int ANGLE_W = 16;
	localparam int VALUE_W = 16;
	localparam int IDX_W   = 4;
	localparam int CFG_W   = 5;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int FIX_W    = 64;
	localparam int ACC_W    = 2 * FIX_W;
	localparam int HALF_W   = FIX_W / 2;
	localparam int FRAC_W   = 61;
	localparam int N_TERMS  = 28;
	localparam int TERM_W   = $clog2(N_TERMS);
	localparam int DIV_BITS = FIX_W;
	localparam int DCNT_W   = $clog2(DIV_BITS);
	localparam int MUL_PP   = 4;
	localparam int MCNT_W   = $clog2(MUL_PP + 1);
	localparam int REM_W    = $clog2(N_TERMS + 1);

	localparam logic [APB_AW-3:0] REG_DIMENSION = '0;
	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

	localparam logic signed [VALUE_W-1:0] Q14_ONE = 16'sd16384;
	localparam logic signed [31:0] Q14_HALF = 32'sd8192;

	localparam logic [FIX_W-1:0] Q61_ONE     = 64'h2000000000000000;
	localparam logic [FIX_W-1:0] Q61_PI      = 64'h6487ED5110B4611A;
	localparam logic [FIX_W-1:0] Q61_HALF_PI = 64'h3243F6A8885A308D;
	localparam logic [FIX_W-1:0] Q61_RND     = 64'h0000400000000000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD,
		S_ADD,
		S_MUL,
		S_DIV_LOAD,
		S_DIV,
		S_ROUND,
		S_PROD,
		S_EMIT_B,
		S_UPDATE,
		S_EMIT_D
	} state_t;

	typedef struct packed {
		logic load;
		logic push_head;
		logic add_term;
		logic mul_step;
		logic div_load;
		logic div_step;
		logic trig_latch;
		logic prod_b;
		logic push_b;
		logic sp_update;
		logic push_d;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic head;
		logic t_zero;
		logic last_term;
		logic mul_done;
		logic div_done;
		logic diag;
		logic out_free;
	} stat_t;

endpackage

/* design/hyperspherical_cholesky_factor.sv */
// Top level of the hyperspherical Cholesky factor block: controller, datapath and APB register.
//
// Angles (signed Q2.13) arrive one beat at a time, row-major over the strict lower triangle
// for rows 1 to dimension-1; each angle yields one to three result beats (signed Q1.14 value
// with its row and column): B(0,0)=1.0 ahead of a matrix's first entry, the entry itself, and
// the row's diagonal after the row's last angle, with last set on the final diagonal. Writing
// the dimension register (byte address 0) restarts the matrix. One angle is worked at a time,
// and the work on it from acceptance to its last beat is set mostly by the Taylor series for
// sine and cosine. Each term update adds the term, runs a multiply built from four 32x32
// partial products, loads the divider and then runs a one-bit-per-cycle divide by the term
// index. The series stops at the first zero term or once its 28th term is added; the reduced
// angle never exceeds pi/2, so a zero term comes after at most 24 updates, and angles near
// zero or near plus or minus pi finish much sooner. Receiver stalls lengthen an angle's work.
// The output register lets the next angle be accepted while the last beat still waits to be
// taken.
module hyperspherical_cholesky_factor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [hcf_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [hcf_pkg::VALUE_W-1:0]  value,
	output logic        [hcf_pkg::IDX_W-1:0]    row,
	output logic        [hcf_pkg::IDX_W-1:0]    col,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [hcf_pkg::APB_AW-1:0]   paddr,
	input  logic        [hcf_pkg::APB_DW-1:0]   pwdata,
	output logic        [hcf_pkg::APB_DW-1:0]   prdata,
	output logic                                pready
);
	import hcf_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic             reg_hit;
	logic             cfg_we;
	logic [CFG_W-1:0] dim;

	assign reg_hit = (paddr[APB_AW-1:2] == REG_DIMENSION);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_DW'(dim) : '0;

	hcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.angle     (angle),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[CFG_W-1:0]),
		.dim       (dim),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.value     (value),
		.row       (row),
		.col       (col),
		.last      (last)
	);

endmodule

/* design/hcf_ctrl.sv */
// Controller state machine sequencing the sine/cosine series and the result beats.
module hcf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hcf_pkg::stat_t stat,
	output hcf_pkg::cmd_t  cmd
);
	import hcf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HEAD;
				end
			end
			S_HEAD: begin
				if (!stat.head) begin
					state_d = S_ADD;
				end else if (stat.out_free) begin
					cmd.push_head = 1'b1;
					state_d       = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_term = 1'b1;
				if (stat.last_term || stat.t_zero) begin
					state_d = S_ROUND;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_done) begin
					state_d = S_DIV_LOAD;
				end
			end
			S_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = S_ADD;
				end
			end
			S_ROUND: begin
				cmd.trig_latch = 1'b1;
				state_d        = S_PROD;
			end
			S_PROD: begin
				cmd.prod_b = 1'b1;
				state_d    = S_EMIT_B;
			end
			S_EMIT_B: begin
				if (stat.out_free) begin
					cmd.push_b = 1'b1;
					state_d    = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.sp_update = 1'b1;
				if (stat.diag) begin
					state_d = S_EMIT_D;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_EMIT_D: begin
				if (stat.out_free) begin
					cmd.push_d  = 1'b1;
					cmd.advance = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/hcf_datapath.sv */
// Datapath: angle reduction, Taylor series with shared multiplier and divider, factor products.
module hcf_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hcf_pkg::cmd_t                        cmd,
	output hcf_pkg::stat_t                       stat,
	input  logic signed [hcf_pkg::ANGLE_W-1:0]   angle,
	input  logic                                 cfg_we,
	input  logic        [hcf_pkg::CFG_W-1:0]     cfg_wdata,
	output logic        [hcf_pkg::CFG_W-1:0]     dim,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [hcf_pkg::VALUE_W-1:0]   value,
	output logic        [hcf_pkg::IDX_W-1:0]     row,
	output logic        [hcf_pkg::IDX_W-1:0]     col,
	output logic                                 last
);
	import hcf_pkg::*;

	function automatic logic [VALUE_W-2:0] q61_to_q14(input logic [FIX_W-1:0] v);
		logic [FIX_W-1:0] clamped;
		logic [FIX_W-1:0] sum;
		if (v[FIX_W-1]) begin
			clamped = '0;
		end else if (v > Q61_ONE) begin
			clamped = Q61_ONE;
		end else begin
			clamped = v;
		end
		sum = clamped + Q61_RND;
		return sum[FRAC_W:FRAC_W-VALUE_W+2];
	endfunction

	logic        [CFG_W-1:0]   dim_q;
	logic        [CNT_W-1:0]   row_q;
	logic        [CNT_W-1:0]   col_q;
	logic signed [VALUE_W-1:0] sp_q;

	logic [FIX_W-1:0]  y_q;
	logic [FIX_W-1:0]  t_q;
	logic [FIX_W-1:0]  s_q;
	logic [FIX_W-1:0]  c_q;
	logic              s_flip_q;
	logic              c_neg_q;
	logic [TERM_W-1:0] n_q;

	logic [MCNT_W-1:0] mcnt_q;
	logic [FIX_W-1:0]  pp_q;
	logic [1:0]        pp_sel_q;
	logic [ACC_W-1:0]  acc_q;

	logic [DCNT_W-1:0] dcnt_q;
	logic [REM_W-1:0]  rem_q;

	logic signed [VALUE_W-1:0] sv_q;
	logic signed [VALUE_W-1:0] cv_q;
	logic signed [VALUE_W-1:0] prod_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic        [IDX_W-1:0]   row_o_q;
	logic        [IDX_W-1:0]   col_o_q;
	logic                      last_q;

	logic [DIM_W-1:0] d_eff;
	logic             fin;
	logic             need_restart;

	logic [ANGLE_W-1:0] mag;
	logic [FIX_W-1:0]   m_load;
	logic [FIX_W-1:0]   y_load;
	logic               s_neg_load;
	logic               c_neg_load;

	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [FIX_W-1:0]  pp_d;
	logic [ACC_W-1:0]  pp_shift;

	logic [REM_W-1:0] divisor;
	logic [REM_W:0]   r_try;
	logic [REM_W:0]   r_diff;
	logic             q_bit;
	logic [REM_W-1:0] rem_next;

	logic [VALUE_W-2:0]        s_mag;
	logic [VALUE_W-2:0]        c_mag;
	logic signed [VALUE_W-1:0] s_ext;
	logic signed [VALUE_W-1:0] c_ext;

	logic signed [VALUE_W-1:0] mul_op;
	logic signed [31:0]        prod_full;
	logic signed [31:0]        prod_sum;
	logic signed [VALUE_W-1:0] prod_rnd;

	logic                      push;
	logic signed [VALUE_W-1:0] value_d;
	logic        [IDX_W-1:0]   row_d;
	logic        [IDX_W-1:0]   col_d;
	logic                      last_d;

	always_comb begin
		if (dim_q < CFG_W'(MIN_DIM)) begin
			d_eff = DIM_W'(MIN_DIM);
		end else if (32'(dim_q) > MAX_DIM) begin
			d_eff = DIM_W'(MAX_DIM);
		end else begin
			d_eff = DIM_W'(dim_q);
		end
	end

	assign fin          = (DIM_W'(row_q) + DIM_W'(1)) == d_eff;
	assign need_restart = (DIM_W'(row_q) >= d_eff) || (col_q >= row_q);

	assign stat.head      = (row_q == CNT_W'(1)) && (col_q == '0);
	assign stat.diag      = (col_q + CNT_W'(1)) == row_q;
	assign stat.t_zero    = (t_q == '0);
	assign stat.last_term = (n_q == TERM_W'(N_TERMS - 1));
	assign stat.mul_done  = (mcnt_q == MCNT_W'(MUL_PP));
	assign stat.div_done  = (dcnt_q == DCNT_W'(DIV_BITS - 1));
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign mag    = angle[ANGLE_W-1] ? ((~angle) + ANGLE_W'(1)) : angle;
	assign m_load = {mag, {(FIX_W - ANGLE_W){1'b0}}};

	always_comb begin
		if (m_load > Q61_PI) begin
			y_load     = m_load - Q61_PI;
			s_neg_load = 1'b1;
			c_neg_load = 1'b1;
		end else if (m_load > Q61_HALF_PI) begin
			y_load     = Q61_PI - m_load;
			s_neg_load = 1'b0;
			c_neg_load = 1'b1;
		end else begin
			y_load     = m_load;
			s_neg_load = 1'b0;
			c_neg_load = 1'b0;
		end
	end

	assign a_half = mcnt_q[1] ? t_q[FIX_W-1:HALF_W] : t_q[HALF_W-1:0];
	assign b_half = mcnt_q[0] ? y_q[FIX_W-1:HALF_W] : y_q[HALF_W-1:0];
	assign pp_d   = a_half * b_half;

	always_comb begin
		case (pp_sel_q)
			2'd0:    pp_shift = {{FIX_W{1'b0}}, pp_q};
			2'd3:    pp_shift = {pp_q, {FIX_W{1'b0}}};
			default: pp_shift = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
		endcase
	end

	assign divisor  = REM_W'(n_q) + REM_W'(1);
	assign r_try    = {rem_q, t_q[FIX_W-1]};
	assign r_diff   = r_try - {1'b0, divisor};
	assign q_bit    = (r_try >= {1'b0, divisor});
	assign rem_next = q_bit ? r_diff[REM_W-1:0] : r_try[REM_W-1:0];

	assign s_mag = q61_to_q14(s_q);
	assign c_mag = q61_to_q14(c_q);
	assign s_ext = {1'b0, s_mag};
	assign c_ext = {1'b0, c_mag};

	assign mul_op    = cmd.sp_update ? sv_q : cv_q;
	assign prod_full = sp_q * mul_op;
	assign prod_sum  = prod_full + Q14_HALF;
	assign prod_rnd  = prod_sum[VALUE_W+13:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
			row_q <= CNT_W'(1);
			col_q <= '0;
			sp_q  <= Q14_ONE;
		end else if (cfg_we) begin
			dim_q <= cfg_wdata;
			row_q <= CNT_W'(1);
			col_q <= '0;
			sp_q  <= Q14_ONE;
		end else begin
			if (cmd.load && need_restart) begin
				row_q <= CNT_W'(1);
				col_q <= '0;
				sp_q  <= Q14_ONE;
			end
			if (cmd.sp_update) begin
				sp_q <= prod_rnd;
			end
			if (cmd.advance) begin
				if (!stat.diag) begin
					col_q <= col_q + CNT_W'(1);
				end else if (fin) begin
					row_q <= CNT_W'(1);
					col_q <= '0;
					sp_q  <= Q14_ONE;
				end else begin
					row_q <= row_q + CNT_W'(1);
					col_q <= '0;
					sp_q  <= Q14_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			mcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				n_q    <= '0;
				mcnt_q <= '0;
			end
			if (cmd.mul_step) begin
				mcnt_q <= stat.mul_done ? '0 : mcnt_q + MCNT_W'(1);
			end
			if (cmd.div_load) begin
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
				if (stat.div_done) begin
					n_q <= n_q + TERM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q      <= y_load;
			t_q      <= Q61_ONE;
			s_q      <= '0;
			c_q      <= '0;
			s_flip_q <= s_neg_load ^ angle[ANGLE_W-1];
			c_neg_q  <= c_neg_load;
		end
		if (cmd.add_term) begin
			case (n_q[1:0])
				2'd0:    c_q <= c_q + t_q;
				2'd1:    s_q <= s_q + t_q;
				2'd2:    c_q <= c_q - t_q;
				default: s_q <= s_q - t_q;
			endcase
		end
		if (cmd.mul_step) begin
			if (mcnt_q == '0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + pp_shift;
			end
			if (!stat.mul_done) begin
				pp_q     <= pp_d;
				pp_sel_q <= mcnt_q[1:0];
			end
		end
		if (cmd.div_load) begin
			t_q   <= acc_q[FRAC_W+FIX_W-1:FRAC_W];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			t_q   <= {t_q[FIX_W-2:0], q_bit};
			rem_q <= rem_next;
		end
		if (cmd.trig_latch) begin
			sv_q <= s_flip_q ? -s_ext : s_ext;
			cv_q <= c_neg_q ? -c_ext : c_ext;
		end
		if (cmd.prod_b) begin
			prod_q <= prod_rnd;
		end
	end

	assign push = cmd.push_head || cmd.push_b || cmd.push_d;

	always_comb begin
		value_d = Q14_ONE;
		row_d   = '0;
		col_d   = '0;
		last_d  = 1'b0;
		if (cmd.push_b) begin
			value_d = prod_q;
			row_d   = IDX_W'(row_q);
			col_d   = IDX_W'(col_q);
		end else if (cmd.push_d) begin
			value_d = sp_q;
			row_d   = IDX_W'(row_q);
			col_d   = IDX_W'(row_q);
			last_d  = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			value_q <= value_d;
			row_o_q <= row_d;
			col_o_q <= col_d;
			last_q  <= last_d;
		end
	end

	assign dim       = dim_q;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign row       = row_o_q;
	assign col       = col_o_q;
	assign last      = last_q;

endmodule

/* design/hcf_checker.sv */
// Port-level checker for the hyperspherical Cholesky factor block and its bind.
`include "hyperspherical_cholesky_factor_defines.svh"

module hcf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [hcf_pkg::VALUE_W-1:0]  value,
	input logic        [hcf_pkg::IDX_W-1:0]    row,
	input logic        [hcf_pkg::IDX_W-1:0]    col,
	input logic                                last
);
	import hcf_pkg::*;

	`HCF_ASSERT_NEXT(a_one_angle_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall, "angle beat accepted while one is in flight")

	`HCF_ASSERT_NOW(a_last_on_diagonal, clk, arst_n, out_valid && last, row == col, "last flag on an off-diagonal beat")

	`HCF_ASSERT_NOW(a_head_entry, clk, arst_n, out_valid && (row == '0), (col == '0) && (value == Q14_ONE) && !last, "row zero beat is not B(0,0) = 1.0")

	`HCF_ASSERT_NEXT(a_stalled_beat_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(value) && $stable(row) && $stable(col), "stalled result beat changed")

endmodule

bind hyperspherical_cholesky_factor hcf_checker u_hcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value),
	.row       (row),
	.col       (col),
	.last      (last)
);
